### rtl/crt_pkg.sv
// Shared types and constants of the chunk reassembly tracker.
// No dependencies; every other file uses it through scoped names.
package crt_pkg;

  localparam int MAX_CHUNKS  = 2048;
  localparam int MAX_MISSING = 63;
  localparam int IDX_W       = $clog2(MAX_CHUNKS);
  localparam int MIDX_W      = 11;
  localparam int MCNT_W      = 6;
  localparam int MISS_CAP    = (MAX_MISSING < 63) ? MAX_MISSING : 63;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 32;

  localparam logic [15:0] EMERG_TOTAL =
    (MAX_CHUNKS > 65535) ? 16'hFFFF : 16'(MAX_CHUNKS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_CHUNKS - 1);
  localparam logic [7:0]  CHUNK_BYTES_RST = 8'd200;
  localparam logic [31:0] TIMEOUT_RST     = 32'd60000;
  localparam logic [7:0]  SIZE_INFO_LEN   = 8'd6;

  typedef enum logic [1:0] {
    FUNC_START = 2'd0,
    FUNC_CHUNK = 2'd1,
    FUNC_END   = 2'd2,
    FUNC_TICK  = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    KIND_STORE    = 3'd0,
    KIND_DUP      = 3'd1,
    KIND_REJECTED = 3'd2,
    KIND_MISSING  = 3'd3,
    KIND_NACK     = 3'd4,
    KIND_ACK      = 3'd5,
    KIND_TIMEOUT  = 3'd6,
    KIND_STARTED  = 3'd7
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CHUNK_BYTES     = 2'd0,
    REG_SESSION_TIMEOUT = 2'd1
  } cfg_reg_t;

  // Idle timer controls from the sequencer.
  typedef struct packed {
    logic clr;
    logic tick;
  } tmr_ctl_t;

endpackage

### rtl/crt_bitmap_ram.sv
// Received-chunk bitmap: one bit per chunk index, synchronous read.
// Depends on crt_pkg for the depth and address width.
module crt_bitmap_ram (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [crt_pkg::IDX_W-1:0] wr_addr,
  input  logic                      wr_data,
  input  logic                      rd_en,
  input  logic [crt_pkg::IDX_W-1:0] rd_addr,
  output logic                      rd_data
);

  logic mem [crt_pkg::MAX_CHUNKS];
  logic rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### rtl/crt_idle_timer.sv
// Saturating millisecond idle counter with timeout compare.
// Depends on crt_pkg for the control struct.
module crt_idle_timer (
  input  logic              clk,
  input  logic              rst_n,
  input  crt_pkg::tmr_ctl_t ctl,
  input  logic [31:0]       timeout,
  output logic              expire
);

  logic [31:0] idle_r;
  logic [31:0] idle_inc;

  // hold at all ones
  assign idle_inc = (idle_r == 32'hFFFF_FFFF) ? idle_r : idle_r + 32'd1;
  assign expire   = idle_inc > timeout;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idle_r <= 32'd0;
    end else if (ctl.clr) begin
      idle_r <= 32'd0;
    end else if (ctl.tick) begin
      idle_r <= idle_inc;
    end
  end

endmodule

### rtl/chunk_reassembly_tracker.sv
// Sequence: start gives its result, then clears the whole bitmap; chunk reads the
//   bitmap, then judges the word (after a bitmap clear when it opens a session); end
//   outside a session and tick are handled from idle; end in a session reads indexes
//   1 to min(total, 2047), one per cycle; the 63rd missing index stops the scan.
// Throughput: one word at a time; busy holds until the last result or clear is done.
// Reset: the whole bitmap is cleared with busy high; no receiver stall.
module chunk_reassembly_tracker (
  input  logic                           clk,
  input  logic                           rst_n,
  // command side
  input  logic                           start,
  output logic                           busy,
  input  logic [1:0]                     in_func,
  input  logic [7:0]                     in_src_node,
  input  logic [15:0]                    in_seq,
  input  logic [7:0]                     in_payload_len,
  input  logic [15:0]                    in_total_in,
  // results
  output logic                           out_valid,
  output logic [2:0]                     out_kind,
  output logic [7:0]                     out_dest_node,
  output logic [15:0]                    out_reply_seq,
  output logic [31:0]                    out_store_offset,
  output logic [7:0]                     out_store_len,
  output logic [10:0]                    out_missing_index,
  output logic [5:0]                     out_missing_count,
  output logic                           out_emergency,
  output logic                           out_last,
  // configuration
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [crt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [crt_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int IW = crt_pkg::IDX_W;

  typedef enum logic [5:0] {
    S_CLEAR  = 6'b000001,
    S_IDLE   = 6'b000010,
    S_CHK_RD = 6'b000100,
    S_CHK_DO = 6'b001000,
    S_SCAN   = 6'b010000,
    S_FINAL  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  // configuration registers
  logic [7:0]  chunk_bytes_r;
  logic [31:0] timeout_r;

  // session control
  logic          session_open_r, session_open_nxt;
  logic [15:0]   total_r, total_nxt;
  logic [15:0]   tx_seq_r, tx_seq_nxt;
  logic          emg_r, emg_nxt;
  logic          resume_chk_r, resume_chk_nxt;
  logic [IW-1:0] clr_addr_r, clr_addr_nxt;

  // scan control
  logic [IW-1:0] hi_r, hi_nxt;
  logic [IW:0]   scan_i_r, scan_i_nxt;
  logic [5:0]    cnt_r, cnt_nxt;
  logic          rd_vld_r, rd_vld_nxt;
  logic [IW-1:0] rd_idx_r, rd_idx_nxt;

  // latched command word
  logic [7:0]     src_r;
  logic [15:0]    seq_r;
  logic [7:0]     plen_r;
  logic [23:0]    prod_r;

  // bitmap port
  logic          ram_we, ram_wdata, ram_re, ram_rdata;
  logic [IW-1:0] ram_waddr, ram_raddr;

  // idle timer
  crt_pkg::tmr_ctl_t tmr_ctl;
  logic              tmr_expire;

  // result being formed this cycle
  logic           em_vld, em_emg, em_last;
  crt_pkg::kind_t em_kind;
  logic [7:0]     em_dest, em_len;
  logic [15:0]    em_rseq;
  logic [31:0]    em_off;
  logic [10:0]    em_midx;
  logic [5:0]     em_mcnt;

  // output registers
  logic           out_valid_r, out_emg_r, out_last_r;
  crt_pkg::kind_t out_kind_r;
  logic [7:0]     out_dest_r, out_len_r;
  logic [15:0]    out_rseq_r;
  logic [31:0]    out_off_r;
  logic [10:0]    out_midx_r;
  logic [5:0]     out_mcnt_r;

  logic          accept;
  logic          seq_in_map;
  logic          end_total_ok;
  logic [15:0]   end_total;
  logic          issue;
  logic          hit;
  logic [IW-1:0] seq_idx;

  assign busy      = (state_r != S_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  assign seq_idx    = seq_r[IW-1:0];
  assign seq_in_map = {1'b0, seq_r} < 17'(crt_pkg::MAX_CHUNKS);

  // an end word carrying a usable total replaces the expected count
  assign end_total_ok = (in_payload_len >= crt_pkg::SIZE_INFO_LEN) && (in_total_in != 16'd0)
                        && ({1'b0, in_total_in} < 17'(crt_pkg::MAX_CHUNKS));
  assign end_total    = end_total_ok ? in_total_in : total_r;

  assign issue = (scan_i_r <= {1'b0, hi_r});
  assign hit   = rd_vld_r && !ram_rdata && (cnt_r < 6'(crt_pkg::MISS_CAP));

  crt_bitmap_ram u_map (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  crt_idle_timer u_tmr (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (tmr_ctl),
    .timeout (timeout_r),
    .expire  (tmr_expire)
  );

  // configuration writes; indexes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chunk_bytes_r <= crt_pkg::CHUNK_BYTES_RST;
      timeout_r     <= crt_pkg::TIMEOUT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        crt_pkg::REG_CHUNK_BYTES:     chunk_bytes_r <= cfg_data[7:0];
        crt_pkg::REG_SESSION_TIMEOUT: timeout_r     <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // Sequencer. Each command word is handled to completion before the next
  // one is taken, so a bitmap write never overlaps a read of the same entry.
  always_comb begin
    state_nxt        = state_r;
    session_open_nxt = session_open_r;
    total_nxt        = total_r;
    tx_seq_nxt       = tx_seq_r;
    emg_nxt          = emg_r;
    resume_chk_nxt   = resume_chk_r;
    clr_addr_nxt     = clr_addr_r;
    hi_nxt           = hi_r;
    scan_i_nxt       = scan_i_r;
    cnt_nxt          = cnt_r;
    rd_vld_nxt       = 1'b0;
    rd_idx_nxt       = scan_i_r[IW-1:0];

    ram_we    = 1'b0;
    ram_waddr = clr_addr_r;
    ram_wdata = 1'b0;
    ram_re    = 1'b0;
    ram_raddr = seq_idx;

    tmr_ctl = '0;

    em_vld  = 1'b0;
    em_kind = crt_pkg::KIND_STORE;
    em_dest = 8'd0;
    em_rseq = 16'd0;
    em_off  = 32'd0;
    em_len  = 8'd0;
    em_midx = 11'd0;
    em_mcnt = 6'd0;
    em_emg  = 1'b0;
    em_last = 1'b0;

    case (state_r)
      S_CLEAR: begin
        // sweep the bitmap one entry per cycle
        ram_we       = 1'b1;
        ram_waddr    = clr_addr_r;
        ram_wdata    = 1'b0;
        clr_addr_nxt = clr_addr_r + IW'(1);
        if (clr_addr_r == crt_pkg::LAST_IDX) begin
          state_nxt      = resume_chk_r ? S_CHK_RD : S_IDLE;
          resume_chk_nxt = 1'b0;
        end
      end

      S_IDLE: begin
        if (accept) begin
          case (in_func)
            crt_pkg::FUNC_START: begin
              tmr_ctl.clr      = 1'b1;
              session_open_nxt = 1'b1;
              total_nxt        = (in_payload_len >= crt_pkg::SIZE_INFO_LEN) ?
                                 in_total_in : 16'd0;
              clr_addr_nxt     = '0;
              resume_chk_nxt   = 1'b0;
              state_nxt        = S_CLEAR;
              em_vld           = 1'b1;
              em_kind          = crt_pkg::KIND_STARTED;
              em_last          = 1'b1;
            end
            crt_pkg::FUNC_CHUNK: begin
              tmr_ctl.clr = 1'b1;
              if (!session_open_r) begin
                // open an emergency session, clear, then handle the chunk
                session_open_nxt = 1'b1;
                total_nxt        = crt_pkg::EMERG_TOTAL;
                emg_nxt          = 1'b1;
                clr_addr_nxt     = '0;
                resume_chk_nxt   = 1'b1;
                state_nxt        = S_CLEAR;
              end else begin
                emg_nxt   = 1'b0;
                state_nxt = S_CHK_RD;
              end
            end
            crt_pkg::FUNC_END: begin
              tmr_ctl.clr = 1'b1;
              if (!session_open_r) begin
                em_vld     = 1'b1;
                em_kind    = crt_pkg::KIND_ACK;
                em_dest    = in_src_node;
                em_rseq    = tx_seq_r;
                em_last    = 1'b1;
                tx_seq_nxt = tx_seq_r + 16'd1;
              end else begin
                total_nxt  = end_total;
                hi_nxt     = ({1'b0, end_total} > 17'(crt_pkg::MAX_CHUNKS - 1)) ?
                             crt_pkg::LAST_IDX : end_total[IW-1:0];
                scan_i_nxt = (IW+1)'(1);
                cnt_nxt    = 6'd0;
                state_nxt  = S_SCAN;
              end
            end
            crt_pkg::FUNC_TICK: begin
              if (session_open_r) begin
                tmr_ctl.tick = 1'b1;
                if (tmr_expire) begin
                  session_open_nxt = 1'b0;
                  em_vld           = 1'b1;
                  em_kind          = crt_pkg::KIND_TIMEOUT;
                  em_last          = 1'b1;
                end
              end
            end
            default: ;
          endcase
        end
      end

      S_CHK_RD: begin
        ram_re    = 1'b1;
        ram_raddr = seq_idx;
        state_nxt = S_CHK_DO;
      end

      S_CHK_DO: begin
        em_vld  = 1'b1;
        em_emg  = emg_r;
        em_last = 1'b1;
        if ((seq_r == 16'd0) || (plen_r == 8'd0)) begin
          em_kind = crt_pkg::KIND_REJECTED;
        end else if (seq_in_map && ram_rdata) begin
          em_kind = crt_pkg::KIND_DUP;
        end else begin
          em_kind = crt_pkg::KIND_STORE;
          em_off  = {8'd0, prod_r};
          em_len  = plen_r;
          if (seq_in_map) begin
            ram_we    = 1'b1;
            ram_waddr = seq_idx;
            ram_wdata = 1'b1;
          end
        end
        state_nxt = S_IDLE;
      end

      S_SCAN: begin
        // issue one read per cycle, judge the word that came back
        if (issue) begin
          ram_re     = 1'b1;
          ram_raddr  = scan_i_r[IW-1:0];
          scan_i_nxt = scan_i_r + (IW+1)'(1);
          rd_vld_nxt = 1'b1;
        end
        if (hit) begin
          em_vld  = 1'b1;
          em_kind = crt_pkg::KIND_MISSING;
          em_midx = 11'(rd_idx_r);
          cnt_nxt = cnt_r + 6'd1;
        end
        if ((hit && (cnt_r + 6'd1 == 6'(crt_pkg::MISS_CAP))) || (!issue && !rd_vld_r)) begin
          state_nxt = S_FINAL;
        end
      end

      S_FINAL: begin
        em_vld     = 1'b1;
        em_dest    = src_r;
        em_rseq    = tx_seq_r;
        em_last    = 1'b1;
        tx_seq_nxt = tx_seq_r + 16'd1;
        if (cnt_r != 6'd0) begin
          em_kind = crt_pkg::KIND_NACK;
          em_mcnt = cnt_r;
        end else begin
          em_kind          = crt_pkg::KIND_ACK;
          session_open_nxt = 1'b0;
        end
        state_nxt = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_CLEAR;
      session_open_r <= 1'b0;
      total_r        <= 16'd0;
      tx_seq_r       <= 16'd0;
      emg_r          <= 1'b0;
      resume_chk_r   <= 1'b0;
      clr_addr_r     <= '0;
      hi_r           <= '0;
      scan_i_r       <= '0;
      cnt_r          <= 6'd0;
      rd_vld_r       <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      session_open_r <= session_open_nxt;
      total_r        <= total_nxt;
      tx_seq_r       <= tx_seq_nxt;
      emg_r          <= emg_nxt;
      resume_chk_r   <= resume_chk_nxt;
      clr_addr_r     <= clr_addr_nxt;
      hi_r           <= hi_nxt;
      scan_i_r       <= scan_i_nxt;
      cnt_r          <= cnt_nxt;
      rd_vld_r       <= rd_vld_nxt;
      out_valid_r    <= em_vld;
    end
  end

  // payload: latch the command word, form the store offset, hold the result
  always_ff @(posedge clk) begin
    if (accept) begin
      src_r  <= in_src_node;
      seq_r  <= in_seq;
      plen_r <= in_payload_len;
    end
    if (state_r == S_CHK_RD) begin
      prod_r <= (seq_r - 16'd1) * chunk_bytes_r;
    end
    rd_idx_r   <= rd_idx_nxt;
    out_kind_r <= em_kind;
    out_dest_r <= em_dest;
    out_rseq_r <= em_rseq;
    out_off_r  <= em_off;
    out_len_r  <= em_len;
    out_midx_r <= em_midx;
    out_mcnt_r <= em_mcnt;
    out_emg_r  <= em_emg;
    out_last_r <= em_last;
  end

  assign out_valid         = out_valid_r;
  assign out_kind          = out_kind_r;
  assign out_dest_node     = out_dest_r;
  assign out_reply_seq     = out_rseq_r;
  assign out_store_offset  = out_off_r;
  assign out_store_len     = out_len_r;
  assign out_missing_index = out_midx_r;
  assign out_missing_count = out_mcnt_r;
  assign out_emergency     = out_emg_r;
  assign out_last          = out_last_r;

endmodule

### rtl/crt_checker.sv
// Port-level checks of the chunk reassembly tracker, bound to the top level.
// Depends on crt_pkg for the function and result codes.
module crt_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic [1:0]  in_func,
  input logic        out_valid,
  input logic [2:0]  out_kind,
  input logic [7:0]  out_store_len,
  input logic [5:0]  out_missing_count,
  input logic        out_last
);

  // the bitmap clear pass holds the block busy out of reset
  a_busy_after_reset: assert property (@(posedge clk) $past(!rst_n) |-> busy)
    else $error("block not busy right after reset");

  // a tick never leaves the block busy
  a_tick_no_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_func == crt_pkg::FUNC_TICK) |=> !busy)
    else $error("tick left the block busy");

  // a missing index is always followed by more results
  a_missing_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == crt_pkg::KIND_MISSING) |-> !out_last)
    else $error("missing index marked last");

  // a nack reports at least one missing chunk
  a_nack_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == crt_pkg::KIND_NACK) |-> (out_missing_count != 6'd0))
    else $error("nack with zero count");

  // empty chunks are rejected, never stored
  a_store_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == crt_pkg::KIND_STORE) |-> (out_store_len != 8'd0))
    else $error("store with zero length");

endmodule

bind chunk_reassembly_tracker crt_checker u_crt_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .start             (start),
  .busy              (busy),
  .in_func           (in_func),
  .out_valid         (out_valid),
  .out_kind          (out_kind),
  .out_store_len     (out_store_len),
  .out_missing_count (out_missing_count),
  .out_last          (out_last)
);
